/* design/dfr_pkg.sv */
// Shared types and constants for the datagram frame receiver.
// No dependencies; used by every module of the block except dfr_in_stage.
package dfr_pkg;

	// Item kinds
	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	// Result kinds
	localparam logic [2:0] RK_PAYLOAD = 3'd0;
	localparam logic [2:0] RK_GOOD    = 3'd1;
	localparam logic [2:0] RK_BAD     = 3'd2;
	localparam logic [2:0] RK_TIMEOUT = 3'd3;
	localparam logic [2:0] RK_LENGTH  = 3'd4;

	// Frame position codes
	localparam logic [2:0] POS_IDLE    = 3'd0;
	localparam logic [2:0] POS_TYPE    = 3'd1;
	localparam logic [2:0] POS_SEQ_HI  = 3'd2;
	localparam logic [2:0] POS_SEQ_LO  = 3'd3;
	localparam logic [2:0] POS_CHK     = 3'd4;
	localparam logic [2:0] POS_LEN     = 3'd5;
	localparam logic [2:0] POS_PAYLOAD = 3'd6;

	localparam logic [7:0] PAYLOAD_MAX = 8'd64;

	// Register map (index by word address bit)
	localparam logic REG_MAGIC   = 1'b0;
	localparam logic REG_TIMEOUT = 1'b1;

	localparam logic [7:0]  MAGIC_RESET   = 8'd0;
	localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  frame_type;
		logic [15:0] sequence_res;
		logic [7:0]  payload_length;
		logic [7:0]  payload_index;
		logic [7:0]  payload_byte;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [1:0] cnt;
		result_t    r0;
		result_t    r1;
	} res_pair_t;

endpackage

/* design/dfr_in_stage.sv */
// Input register of the frame receiver: holds one item until the core takes it.
// Depends on nothing but the clock and reset.
module dfr_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       kind,
	input  logic [7:0] rx_byte,
	input  logic       take,
	output logic       valid_s1,
	output logic       kind_s1,
	output logic [7:0] byte_s1
);

	assign in_stall = valid_s1 && !take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			kind_s1 <= kind;
			byte_s1 <= rx_byte;
		end
	end

endmodule

/* design/dfr_frame_core.sv */
// Frame parser state and per-item decode: header capture, checksum, timeout.
// Uses dfr_pkg for codes and the result record types.
module dfr_frame_core #(
	parameter logic [7:0] PAYLOAD_MAX = dfr_pkg::PAYLOAD_MAX
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_s1,
	input  logic               kind_s1,
	input  logic [7:0]         byte_s1,
	input  logic               take,
	input  logic [7:0]         magic,
	input  logic [15:0]        timeout,
	output dfr_pkg::res_pair_t res
);

	logic [2:0]  pos_q, pos_n;
	logic [7:0]  type_q, type_n;
	logic [15:0] seq_q, seq_n;
	logic [7:0]  chk_q, chk_n;
	logic [7:0]  len_q, len_n;
	logic [7:0]  sum_q, sum_n;
	logic [15:0] wait_q, wait_n;
	logic [7:0]  idx_q, idx_n;
	logic [15:0] wait_inc;
	logic [2:0]  status;

	assign wait_inc = (wait_q == 16'hFFFF) ? wait_q : wait_q + 16'd1;

	always_comb begin
		pos_n  = pos_q;
		type_n = type_q;
		seq_n  = seq_q;
		chk_n  = chk_q;
		len_n  = len_q;
		sum_n  = sum_q;
		wait_n = wait_q;
		idx_n  = idx_q;
		res    = '0;
		if (pos_q == dfr_pkg::POS_IDLE) begin
			if (kind_s1 == dfr_pkg::KIND_BYTE && byte_s1 == magic) begin
				pos_n  = dfr_pkg::POS_TYPE;
				type_n = '0;
				seq_n  = '0;
				chk_n  = '0;
				len_n  = '0;
				sum_n  = '0;
				wait_n = '0;
				idx_n  = '0;
			end
		end else if (kind_s1 == dfr_pkg::KIND_TICK) begin
			wait_n = wait_inc;
			if (wait_inc >= timeout) begin
				res.cnt     = 2'd1;
				res.r0.kind = dfr_pkg::RK_TIMEOUT;
				res.r0.last = 1'b1;
				pos_n       = dfr_pkg::POS_IDLE;
			end
		end else begin
			wait_n = '0;
			unique case (pos_q)
				dfr_pkg::POS_TYPE: begin
					type_n = byte_s1;
					sum_n  = sum_q + byte_s1;
					pos_n  = dfr_pkg::POS_SEQ_HI;
				end
				dfr_pkg::POS_SEQ_HI: begin
					seq_n = {byte_s1, 8'd0};
					pos_n = dfr_pkg::POS_SEQ_LO;
				end
				dfr_pkg::POS_SEQ_LO: begin
					seq_n = {seq_q[15:8], byte_s1};
					sum_n = sum_q + byte_s1;
					pos_n = dfr_pkg::POS_CHK;
				end
				dfr_pkg::POS_CHK: begin
					chk_n = byte_s1;
					pos_n = dfr_pkg::POS_LEN;
				end
				dfr_pkg::POS_LEN: begin
					len_n = byte_s1;
					if (byte_s1 > PAYLOAD_MAX) begin
						res.cnt     = 2'd1;
						res.r0.kind = dfr_pkg::RK_LENGTH;
						res.r0.last = 1'b1;
						pos_n       = dfr_pkg::POS_IDLE;
					end else begin
						sum_n = sum_q + byte_s1;
						if (byte_s1 == 8'd0) begin
							// empty frame: status straight away
							res.cnt     = 2'd1;
							res.r0.kind = (sum_n == chk_q) ? dfr_pkg::RK_GOOD : dfr_pkg::RK_BAD;
							res.r0.last = 1'b1;
							pos_n       = dfr_pkg::POS_IDLE;
						end else begin
							pos_n = dfr_pkg::POS_PAYLOAD;
						end
					end
				end
				default: begin
					sum_n                = sum_q + byte_s1;
					res.r0.kind          = dfr_pkg::RK_PAYLOAD;
					res.r0.payload_index = idx_q;
					res.r0.payload_byte  = byte_s1;
					if ({1'b0, idx_q} + 9'd1 >= {1'b0, len_q}) begin
						// last payload byte: byte then status
						res.cnt     = 2'd2;
						res.r1.kind = (sum_n == chk_q) ? dfr_pkg::RK_GOOD : dfr_pkg::RK_BAD;
						res.r1.last = 1'b1;
						pos_n       = dfr_pkg::POS_IDLE;
					end else begin
						res.cnt     = 2'd1;
						res.r0.last = 1'b1;
						idx_n       = idx_q + 8'd1;
					end
				end
			endcase
		end
		res.r0.frame_type     = type_n;
		res.r0.sequence_res   = seq_n;
		res.r0.payload_length = len_n;
		res.r1.frame_type     = type_n;
		res.r1.sequence_res   = seq_n;
		res.r1.payload_length = len_n;
		status                = res.r1.kind;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= dfr_pkg::POS_IDLE;
			type_q <= '0;
			seq_q  <= '0;
			chk_q  <= '0;
			len_q  <= '0;
			sum_q  <= '0;
			wait_q <= '0;
			idx_q  <= '0;
		end else if (valid_s1 && take) begin
			pos_q  <= pos_n;
			type_q <= type_n;
			seq_q  <= seq_n;
			chk_q  <= chk_n;
			len_q  <= len_n;
			sum_q  <= sum_n;
			wait_q <= wait_n;
			idx_q  <= idx_n;
		end
	end

	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q == dfr_pkg::POS_IDLE |-> res.cnt == 2'd0)
		else $error("result raised outside a frame");

	a_pair_shape: assert property (@(posedge clk) disable iff (!arst_n)
		res.cnt == 2'd2 |-> res.r0.kind == dfr_pkg::RK_PAYLOAD && !res.r0.last && res.r1.last
			&& (status == dfr_pkg::RK_GOOD || status == dfr_pkg::RK_BAD))
		else $error("two-result item is not payload then status");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		res.cnt == 2'd1 |-> res.r0.last)
		else $error("single result not marked last");

endmodule

/* design/dfr_out_queue.sv */
// Two-entry result register queue feeding the output channel.
// Uses dfr_pkg result record types.
module dfr_out_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  dfr_pkg::res_pair_t push,
	input  logic [1:0]         push_cnt,
	output logic [1:0]         room,
	input  logic               out_stall,
	output logic               out_valid,
	output dfr_pkg::result_t   head
);

	logic [1:0]       cnt_q;
	logic [1:0]       cnt_left;
	logic             pop;
	dfr_pkg::result_t slot0_q, slot1_q;
	dfr_pkg::result_t slot0_n, slot1_n;

	assign out_valid = (cnt_q != 2'd0);
	assign head      = slot0_q;
	assign pop       = out_valid && !out_stall;
	assign cnt_left  = cnt_q - {1'b0, pop};
	assign room      = 2'd2 - cnt_left;

	always_comb begin
		slot0_n = pop ? slot1_q : slot0_q;
		slot1_n = slot1_q;
		if (cnt_left == 2'd0) begin
			if (push_cnt != 2'd0) begin
				slot0_n = push.r0;
			end
			if (push_cnt == 2'd2) begin
				slot1_n = push.r1;
			end
		end else if (push_cnt != 2'd0) begin
			// append behind the held item
			slot1_n = push.r0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_left + push_cnt;
		end
	end

	always_ff @(posedge clk) begin
		slot0_q <= slot0_n;
		slot1_q <= slot1_n;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push_cnt <= room)
		else $error("results pushed beyond free entries");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("queue count out of range");

endmodule

/* design/datagram_frame_receiver_top.sv */
// Top level of the datagram frame receiver: APB registers, input stage,
// frame core and output queue. Depends on dfr_pkg and the dfr_* modules.
// An accepted item waits in the input register, the frame core decodes it, and its
// results go to the output queue registers. Throughput: one item per cycle while the
// queue has room; the last payload byte yields two results for the two-entry queue.
// Reset (arst_n low) idles the parser, empties the queue, magic to 0, timeout to 1000.
module datagram_frame_receiver_top #(
	parameter logic [7:0] PAYLOAD_MAX = dfr_pkg::PAYLOAD_MAX
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  result_kind,
	output logic [7:0]  frame_type,
	output logic [15:0] sequence_res,
	output logic [7:0]  payload_length,
	output logic [7:0]  payload_index,
	output logic [7:0]  payload_byte,
	output logic        last_of_run
);

	logic [7:0]         magic_q;
	logic [15:0]        timeout_q;
	logic               valid_s1;
	logic               kind_s1;
	logic [7:0]         byte_s1;
	logic               take;
	logic [1:0]         room;
	logic [1:0]         push_cnt;
	dfr_pkg::res_pair_t res;
	dfr_pkg::result_t   head;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q   <= dfr_pkg::MAGIC_RESET;
			timeout_q <= dfr_pkg::TIMEOUT_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				dfr_pkg::REG_MAGIC:   magic_q   <= pwdata[7:0];
				dfr_pkg::REG_TIMEOUT: timeout_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			dfr_pkg::REG_MAGIC:   prdata = {24'd0, magic_q};
			dfr_pkg::REG_TIMEOUT: prdata = {16'd0, timeout_q};
			default:              prdata = '0;
		endcase
	end

	// take the held item only if its results fit in the queue
	assign take     = valid_s1 && (res.cnt <= room);
	assign push_cnt = take ? res.cnt : 2'd0;

	dfr_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.kind     (kind),
		.rx_byte  (rx_byte),
		.take     (take),
		.valid_s1 (valid_s1),
		.kind_s1  (kind_s1),
		.byte_s1  (byte_s1)
	);

	dfr_frame_core #(
		.PAYLOAD_MAX (PAYLOAD_MAX)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.kind_s1  (kind_s1),
		.byte_s1  (byte_s1),
		.take     (take),
		.magic    (magic_q),
		.timeout  (timeout_q),
		.res      (res)
	);

	dfr_out_queue u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res),
		.push_cnt  (push_cnt),
		.room      (room),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.head      (head)
	);

	assign result_kind    = head.kind;
	assign frame_type     = head.frame_type;
	assign sequence_res   = head.sequence_res;
	assign payload_length = head.payload_length;
	assign payload_index  = head.payload_index;
	assign payload_byte   = head.payload_byte;
	assign last_of_run    = head.last;

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for datagram_frame_receiver_top: directed and random frames,
// ticks and noise; a scoreboard tracks frame state and checks every result in order.
// Depends on dfr_pkg and the datagram_frame_receiver_top RTL only.

import dfr_pkg::*;

class frame_scoreboard;
	result_t    pending_q[$];
	int         mismatches;
	logic [7:0] magic_r;
	logic [15:0] timeout_r;
	logic [2:0] stage;
	logic [7:0] next_idx;
	logic [7:0] frame_type_r;
	logic [15:0] seq_r;
	logic [7:0] chk_r;
	logic [7:0] len_r;
	logic [7:0] sum_r;
	logic [15:0] idle_ticks;

	function new();
		mismatches = 0;
		magic_r = MAGIC_RESET;
		timeout_r = TIMEOUT_RESET;
		clear_frame();
	endfunction

	function void clear_frame();
		stage = POS_IDLE;
		next_idx = '0;
		frame_type_r = '0;
		seq_r = '0;
		chk_r = '0;
		len_r = '0;
		sum_r = '0;
		idle_ticks = '0;
	endfunction

	function void write_reg(logic [2:0] addr, logic [31:0] data);
		if (addr[2] == REG_MAGIC) begin
			magic_r = data[7:0];
		end else begin
			timeout_r = data[15:0];
		end
	endfunction

	function int pending();
		return pending_q.size();
	endfunction

	function void push(logic [2:0] rk, logic [7:0] idx, logic [7:0] val, logic end_flag);
		result_t r;
		r.kind = rk;
		r.frame_type = frame_type_r;
		r.sequence_res = seq_r;
		r.payload_length = len_r;
		r.payload_index = idx;
		r.payload_byte = val;
		r.last = end_flag;
		pending_q.push_back(r);
	endfunction

	function logic [2:0] frame_status();
		return (sum_r == chk_r) ? RK_GOOD : RK_BAD;
	endfunction

	// Advance the frame state by one accepted item and queue what it produces
	function void note_item(logic item_kind, logic [7:0] b);
		if (stage == POS_IDLE) begin
			if (item_kind == KIND_BYTE && b == magic_r) begin
				clear_frame();
				stage = POS_TYPE;
			end
			return;
		end
		if (item_kind == KIND_TICK) begin
			if (idle_ticks != 16'hFFFF)
				idle_ticks++;
			if (idle_ticks >= timeout_r) begin
				push(RK_TIMEOUT, '0, '0, 1'b1);
				clear_frame();
			end
			return;
		end
		idle_ticks = '0;
		case (stage)
			POS_TYPE: begin
				frame_type_r = b;
				sum_r += b;
				stage = POS_SEQ_HI;
			end
			POS_SEQ_HI: begin
				seq_r = {b, 8'h00};
				stage = POS_SEQ_LO;
			end
			POS_SEQ_LO: begin
				seq_r[7:0] = b;
				sum_r += b;
				stage = POS_CHK;
			end
			POS_CHK: begin
				chk_r = b;
				stage = POS_LEN;
			end
			POS_LEN: begin
				len_r = b;
				if (b > PAYLOAD_MAX) begin
					push(RK_LENGTH, '0, '0, 1'b1);
					clear_frame();
				end else begin
					sum_r += b;
					if (b == 8'd0) begin
						push(frame_status(), '0, '0, 1'b1);
						clear_frame();
					end else begin
						stage = POS_PAYLOAD;
						next_idx = '0;
					end
				end
			end
			default: begin
				sum_r += b;
				if ({1'b0, next_idx} + 9'd1 >= {1'b0, len_r}) begin
					push(RK_PAYLOAD, next_idx, b, 1'b0);
					push(frame_status(), '0, '0, 1'b1);
					clear_frame();
				end else begin
					push(RK_PAYLOAD, next_idx, b, 1'b1);
					next_idx++;
				end
			end
		endcase
	endfunction

	function void report(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s", $time, msg);
	endfunction

	function void check_result(result_t got);
		result_t want;
		if (pending_q.size() == 0) begin
			report($sformatf("unexpected result kind %0d type %02h seq %04h len %0d idx %0d byte %02h last %0b",
				got.kind, got.frame_type, got.sequence_res, got.payload_length,
				got.payload_index, got.payload_byte, got.last));
			return;
		end
		want = pending_q.pop_front();
		if (got.kind !== want.kind || got.frame_type !== want.frame_type ||
				got.sequence_res !== want.sequence_res ||
				got.payload_length !== want.payload_length ||
				got.payload_index !== want.payload_index ||
				got.payload_byte !== want.payload_byte || got.last !== want.last)
			report($sformatf({"mismatch: expected kind %0d type %02h seq %04h len %0d idx %0d ",
				"byte %02h last %0b, got kind %0d type %02h seq %04h len %0d idx %0d byte %02h last %0b"},
				want.kind, want.frame_type, want.sequence_res, want.payload_length,
				want.payload_index, want.payload_byte, want.last,
				got.kind, got.frame_type, got.sequence_res, got.payload_length,
				got.payload_index, got.payload_byte, got.last));
	endfunction
endclass

module testbench;
	localparam int QUIET_LIMIT = 4000;
	localparam int PHASE_ITEMS = 200;
	localparam logic [2:0] MAGIC_ADDR   = {REG_MAGIC, 2'b00};
	localparam logic [2:0] TIMEOUT_ADDR = {REG_TIMEOUT, 2'b00};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        kind = KIND_BYTE;
	logic [7:0]  rx_byte = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  result_kind;
	logic [7:0]  frame_type;
	logic [15:0] sequence_res;
	logic [7:0]  payload_length;
	logic [7:0]  payload_index;
	logic [7:0]  payload_byte;
	logic        last_of_run;

	frame_scoreboard sb = new();
	int          send_idle_pct = 31;
	int          recv_stall_pct = 69;
	int          frame_items = 0;
	int          quiet_cycles = 0;
	logic [7:0]  cur_magic;
	logic [15:0] cur_timeout;

	datagram_frame_receiver_top DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .kind(kind), .rx_byte(rx_byte),
		.out_valid(out_valid), .out_stall(out_stall), .result_kind(result_kind),
		.frame_type(frame_type), .sequence_res(sequence_res),
		.payload_length(payload_length), .payload_index(payload_index),
		.payload_byte(payload_byte), .last_of_run(last_of_run)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Monitor both channels and guard against a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_item(kind, rx_byte);
			if (out_valid && !out_stall)
				sb.check_result('{result_kind, frame_type, sequence_res, payload_length,
					payload_index, payload_byte, last_of_run});
		end
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic reg_write(logic [2:0] addr, logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(addr, data);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_item(logic k, logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		kind <= k;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
	endtask

	// Drop valid and let the block empty before touching the registers
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(logic [7:0] magic, logic [15:0] timeout);
		reg_write(MAGIC_ADDR, {24'h0, magic});
		reg_write(TIMEOUT_ADDR, {16'h0, timeout});
		cur_magic = magic;
		cur_timeout = timeout;
	endtask

	task automatic send_noise();
		logic [7:0] b;
		repeat ($urandom_range(2)) begin
			if ($urandom_range(1)) begin
				send_item(KIND_TICK, 8'($urandom));
			end else begin
				b = 8'($urandom);
				// now and then a stray start marker, which shifts the next frame
				if (b == cur_magic && $urandom_range(9) != 0)
					b ^= 8'h01;
				send_item(KIND_BYTE, b);
			end
		end
	endtask

	task automatic send_frame();
		logic [7:0] hdr [6];
		logic [7:0] body [64];
		logic [7:0] len;
		logic [7:0] sum;
		int roll;
		int cut_at;
		int n_bytes;
		int gap;
		roll = $urandom_range(99);
		if (roll < 8)
			len = 8'($urandom_range(255, 65));
		else if (roll < 14)
			len = 8'd0;
		else if (roll < 17)
			len = PAYLOAD_MAX;
		else if (roll < 25)
			len = 8'($urandom_range(63, 9));
		else
			len = 8'($urandom_range(8, 1));
		hdr[0] = cur_magic;
		hdr[1] = 8'($urandom);
		hdr[2] = 8'($urandom);
		hdr[3] = 8'($urandom);
		hdr[5] = len;
		sum = hdr[1] + hdr[3] + len;
		n_bytes = 6;
		if (len <= PAYLOAD_MAX) begin
			for (int i = 0; i < len; i++) begin
				body[i] = ($urandom_range(19) == 0) ? cur_magic : 8'($urandom);
				sum += body[i];
			end
			n_bytes = 6 + len;
		end
		hdr[4] = ($urandom_range(99) < 75) ? sum : 8'($urandom);
		cut_at = (cur_timeout <= 16 && $urandom_range(99) < 12) ?
			$urandom_range(n_bytes - 1, 1) : n_bytes;
		for (int i = 0; i < n_bytes; i++) begin
			if (i == cut_at) begin
				// go silent long enough to abort the frame
				repeat (cur_timeout) send_item(KIND_TICK, 8'($urandom));
				break;
			end
			if (i > 0 && $urandom_range(99) < 15) begin
				gap = $urandom_range(cur_timeout > 4 ? 3 : cur_timeout - 1, 0);
				repeat (gap) send_item(KIND_TICK, 8'($urandom));
			end
			send_item(KIND_BYTE, (i < 6) ? hdr[i] : body[i - 6]);
		end
		frame_items += n_bytes;
	endtask

	task automatic run_phase(logic [7:0] magic, logic [15:0] timeout, int idle_pct, int stall_pct);
		drain();
		configure(magic, timeout);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		frame_items = 0;
		while (frame_items < PHASE_ITEMS) begin
			send_noise();
			send_frame();
		end
	endtask

	task automatic run_directed();
		logic [8:0] items [27] = '{
			{KIND_TICK, 8'h00}, {KIND_BYTE, 8'h00},
			// zero length with a wrong checksum, all-ones type and sequence
			{KIND_BYTE, 8'hA5}, {KIND_BYTE, 8'hFF}, {KIND_BYTE, 8'hFF}, {KIND_BYTE, 8'hFF},
			{KIND_BYTE, 8'h00}, {KIND_BYTE, 8'h00},
			// length one past the maximum
			{KIND_BYTE, 8'hA5}, {KIND_BYTE, 8'h00}, {KIND_BYTE, 8'h00}, {KIND_BYTE, 8'h00},
			{KIND_BYTE, 8'h00}, {KIND_BYTE, 8'h41},
			// good frame, a tick inside, start marker used as payload
			{KIND_BYTE, 8'hA5}, {KIND_BYTE, 8'h01}, {KIND_BYTE, 8'h80}, {KIND_BYTE, 8'h7F},
			{KIND_TICK, 8'hFF}, {KIND_BYTE, 8'h81}, {KIND_BYTE, 8'h02}, {KIND_BYTE, 8'hA5},
			{KIND_BYTE, 8'h5A},
			// silence aborts the frame
			{KIND_BYTE, 8'hA5}, {KIND_BYTE, 8'h33}, {KIND_TICK, 8'h00}, {KIND_TICK, 8'h00}
		};
		configure(8'hA5, 16'd2);
		foreach (items[i])
			send_item(items[i][8], items[i][7:0]);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		run_directed();
		run_phase(8'h00, 16'd1, 31, 69);
		run_phase(8'hFF, 16'($urandom_range(6, 2)), 69, 31);
		run_phase(8'($urandom), 16'hFFFF, 0, 0);
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
